// ----- design/prfe_pkg.sv -----
// shared types and constants for the protobuf record field extractor
// no dependencies; imported by every module of the block
`default_nettype none

package prfe_pkg;

    localparam int unsigned MAX_BYTES_W = 17;
    localparam logic [MAX_BYTES_W-1:0] MAX_BYTES_RESET = 17'h10000;

    // result status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_VARINT = 3'd1;
    localparam logic [2:0] ST_BAD_WIRE   = 3'd2;
    localparam logic [2:0] ST_TRUNC      = 3'd3;
    localparam logic [2:0] ST_TOO_LONG   = 3'd4;

    // wire types that the decoder understands
    localparam logic [2:0] WT_VARINT  = 3'd0;
    localparam logic [2:0] WT_FIXED64 = 3'd1;
    localparam logic [2:0] WT_LEN     = 3'd2;
    localparam logic [2:0] WT_FIXED32 = 3'd5;

    // captured field numbers
    localparam logic [28:0] FLD_USER_ID    = 29'd2;
    localparam logic [28:0] FLD_ACCOUNT_ID = 29'd4;
    localparam logic [28:0] FLD_FAKE       = 29'd5;
    localparam logic [28:0] FLD_SPECTATOR  = 29'd6;

    // last byte index of a varint (bits 63 and up)
    localparam logic [3:0] VARINT_LAST_IDX = 4'd9;
    localparam logic [3:0] FIXED64_LAST_IDX = 4'd7;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_final;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] user_id;
        logic [63:0] account_id;
        logic        fake_flag;
        logic        spectator_flag;
    } out_beat_t;

endpackage

`default_nettype wire

// ----- design/protobuf_record_field_extractor.sv -----
// top level of the protobuf record field extractor
// depends on prfe_pkg, prfe_in_stage, prfe_parser and prfe_out_stage
//
// Takes one message byte per beat and decodes the protobuf wire format on the fly;
// a result beat leaves only for the byte flagged final. Throughput is one byte per
// clock: the parser state advances out of the input register on each taken byte. A
// non-final byte never waits on the output side; a final byte moves on only when the
// result register is empty or being read in that cycle. The result beat of a final
// byte is offered after passing the input register and then the result register,
// which it enters only when free. The user must write max_bytes_reg through cfg_we/
// cfg_wdata only while no message is in flight; the block does not enforce this.
`default_nettype none

module protobuf_record_field_extractor (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire prfe_pkg::in_beat_t               s_data,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output prfe_pkg::out_beat_t                   m_data,
    input  wire logic                             cfg_we,
    input  wire logic [prfe_pkg::MAX_BYTES_W-1:0] cfg_wdata
);
    import prfe_pkg::*;

    logic [MAX_BYTES_W-1:0] max_bytes_reg;
    logic                   beat_valid;
    in_beat_t               beat;
    logic                   take;
    logic                   out_free;
    out_beat_t              result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_bytes_reg <= MAX_BYTES_RESET;
        end else if (cfg_we) begin
            max_bytes_reg <= cfg_wdata;
        end
    end

    // a final beat needs room in the result register
    assign take = beat_valid && (!beat.is_final || out_free);

    prfe_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .take       (take),
        .beat_valid (beat_valid),
        .beat       (beat)
    );

    prfe_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (take),
        .beat      (beat),
        .max_bytes (max_bytes_reg),
        .result    (result)
    );

    prfe_out_stage u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (take && beat.is_final),
        .result  (result),
        .free    (out_free),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

// ----- design/prfe_in_stage.sv -----
// input register for message bytes
// depends on prfe_pkg for the input beat type
`default_nettype none

module prfe_in_stage (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire prfe_pkg::in_beat_t s_data,
    input  wire logic             take,
    output logic                  beat_valid,
    output prfe_pkg::in_beat_t    beat
);
    import prfe_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_beat_t beat_reg;

    // register is free when empty or being drained this cycle
    assign s_ready = !valid_reg || take;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (s_valid && s_ready) begin
            beat_reg <= s_data;
        end
    end

    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

endmodule

`default_nettype wire

// ----- design/prfe_parser.sv -----
// wire-format parser state and per-byte next-state logic
// depends on prfe_pkg for beat types, status and field constants
`default_nettype none

module prfe_parser (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                step,
    input  wire prfe_pkg::in_beat_t                  beat,
    input  wire logic [prfe_pkg::MAX_BYTES_W-1:0]    max_bytes,
    output prfe_pkg::out_beat_t                      result
);
    import prfe_pkg::*;

    typedef enum logic [2:0] {
        PH_KEY,
        PH_VARVAL,
        PH_FIXED,
        PH_LEN,
        PH_SKIP
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [3:0]             vidx_reg, vidx_next;
    logic [63:0]            acc_reg, acc_next;
    logic [28:0]            fnum_reg, fnum_next;
    logic [63:0]            rem_reg, rem_next;
    logic [MAX_BYTES_W-1:0] count_reg, count_next;
    logic [2:0]             err_reg, err_next;
    logic [63:0]            user_reg, user_next;
    logic [63:0]            acct_reg, acct_next;
    logic                   fake_reg, fake_next;
    logic                   spec_reg, spec_next;

    logic [6:0]  shamt;
    logic [63:0] acc_ins;
    logic [63:0] fix_acc;
    logic        varint_bad;
    logic        key_bad;
    logic [28:0] key_fnum;
    logic [2:0]  key_wt;
    logic        wrong_type;
    logic [2:0]  status;

    // varint byte n lands at bit 7*n
    assign shamt   = 7'(vidx_reg) * 7'd7;
    assign acc_ins = acc_reg | ({57'd0, beat.data_byte[6:0]} << shamt[5:0]);
    assign fix_acc = acc_reg | ({56'd0, beat.data_byte} << {vidx_reg[2:0], 3'b000});

    // tenth byte may only carry bit 63
    assign varint_bad = (vidx_reg == VARINT_LAST_IDX) && (beat.data_byte[7:1] != 7'd0);

    assign key_fnum   = acc_ins[31:3];
    assign key_wt     = acc_ins[2:0];
    assign key_bad    = (acc_ins[63:3] == 61'd0) || (acc_ins[63:32] != 32'd0);
    assign wrong_type = (((key_fnum == FLD_USER_ID) || (key_fnum == FLD_ACCOUNT_ID))
                         && (key_wt != WT_FIXED64))
                     || (((key_fnum == FLD_FAKE) || (key_fnum == FLD_SPECTATOR))
                         && (key_wt != WT_VARINT));

    always_comb begin
        phase_next = phase_reg;
        vidx_next  = vidx_reg;
        acc_next   = acc_reg;
        fnum_next  = fnum_reg;
        rem_next   = rem_reg;
        count_next = count_reg;
        err_next   = err_reg;
        user_next  = user_reg;
        acct_next  = acct_reg;
        fake_next  = fake_reg;
        spec_next  = spec_reg;

        if (count_reg >= max_bytes) begin
            err_next = ST_TOO_LONG;
        end else begin
            count_next = count_reg + 1'b1;
            if (err_reg == ST_OK) begin
                case (phase_reg)
                    PH_KEY, PH_VARVAL, PH_LEN: begin
                        if (varint_bad) begin
                            err_next = ST_BAD_VARINT;
                        end else if (beat.data_byte[7]) begin
                            acc_next  = acc_ins;
                            vidx_next = vidx_reg + 1'b1;
                        end else begin
                            acc_next   = '0;
                            vidx_next  = '0;
                            phase_next = PH_KEY;
                            case (phase_reg)
                                PH_KEY: begin
                                    if (key_bad) begin
                                        err_next = ST_BAD_VARINT;
                                    end else begin
                                        fnum_next = key_fnum;
                                        if (wrong_type) begin
                                            err_next = ST_BAD_WIRE;
                                        end else begin
                                            case (key_wt)
                                                WT_VARINT:  phase_next = PH_VARVAL;
                                                WT_FIXED64: phase_next = PH_FIXED;
                                                WT_LEN:     phase_next = PH_LEN;
                                                WT_FIXED32: begin
                                                    phase_next = PH_SKIP;
                                                    rem_next   = 64'd4;
                                                end
                                                default:    err_next = ST_BAD_WIRE;
                                            endcase
                                        end
                                    end
                                end
                                PH_VARVAL: begin
                                    if (fnum_reg == FLD_FAKE) begin
                                        fake_next = |acc_ins;
                                    end
                                    if (fnum_reg == FLD_SPECTATOR) begin
                                        spec_next = |acc_ins;
                                    end
                                end
                                default: begin
                                    // length prefix; zero length goes straight to next key
                                    if (acc_ins != 64'd0) begin
                                        phase_next = PH_SKIP;
                                        rem_next   = acc_ins;
                                    end
                                end
                            endcase
                        end
                    end
                    PH_FIXED: begin
                        if (vidx_reg == FIXED64_LAST_IDX) begin
                            if (fnum_reg == FLD_USER_ID) begin
                                user_next = fix_acc;
                            end
                            if (fnum_reg == FLD_ACCOUNT_ID) begin
                                acct_next = fix_acc;
                            end
                            acc_next   = '0;
                            vidx_next  = '0;
                            phase_next = PH_KEY;
                        end else begin
                            acc_next  = fix_acc;
                            vidx_next = vidx_reg + 1'b1;
                        end
                    end
                    PH_SKIP: begin
                        if (rem_reg != 64'd0) begin
                            rem_next = rem_reg - 1'b1;
                        end
                        if (rem_reg <= 64'd1) begin
                            phase_next = PH_KEY;
                            acc_next   = '0;
                            vidx_next  = '0;
                        end
                    end
                    default: begin
                        phase_next = PH_KEY;
                    end
                endcase
            end
        end

        status = err_next;
        if ((status == ST_OK) && ((phase_next != PH_KEY) || (vidx_next != 4'd0))) begin
            status = ST_TRUNC;
        end
        result.status = status;
        if (status == ST_OK) begin
            result.user_id        = user_next;
            result.account_id     = acct_next;
            result.fake_flag      = fake_next;
            result.spectator_flag = spec_next;
        end else begin
            result.user_id        = '0;
            result.account_id     = '0;
            result.fake_flag      = 1'b0;
            result.spectator_flag = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (step && beat.is_final)) begin
            phase_reg <= PH_KEY;
            vidx_reg  <= '0;
            acc_reg   <= '0;
            fnum_reg  <= '0;
            rem_reg   <= '0;
            count_reg <= '0;
            err_reg   <= ST_OK;
            user_reg  <= '0;
            acct_reg  <= '0;
            fake_reg  <= 1'b0;
            spec_reg  <= 1'b0;
        end else if (step) begin
            phase_reg <= phase_next;
            vidx_reg  <= vidx_next;
            acc_reg   <= acc_next;
            fnum_reg  <= fnum_next;
            rem_reg   <= rem_next;
            count_reg <= count_next;
            err_reg   <= err_next;
            user_reg  <= user_next;
            acct_reg  <= acct_next;
            fake_reg  <= fake_next;
            spec_reg  <= spec_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/prfe_out_stage.sv -----
// result register toward the output channel
// depends on prfe_pkg for the result beat type
`default_nettype none

module prfe_out_stage (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                load,
    input  wire prfe_pkg::out_beat_t result,
    output logic                     free,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output prfe_pkg::out_beat_t      m_data
);
    import prfe_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    out_beat_t data_reg;

    assign free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (load) begin
            data_reg <= result;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

`default_nettype wire
